@@ sv/vmr_pkg.sv @@
// Shared types, widths and constants for the vibration moving RMS block.
package vmr_pkg;

    localparam int ACC_W      = 16;     // raw sample width
    localparam int Q_SH       = 16;     // Q16 fraction bits of gravity
    localparam int G_W        = 34;     // gravity register width
    localparam int DYN_W      = 17;     // dynamic part, whole counts
    localparam int SQ_W       = 34;     // sum of three squares
    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;

    localparam int ALPHA_W    = 16;
    localparam int INTV_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int MUL_A_W    = ALPHA_W + 2;
    localparam int MUL_B_W    = G_W + 1;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

    localparam int RMS_W      = 25;
    localparam int FCNT_W     = 7;

    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd62915;
    localparam logic [INTV_W-1:0]  INTV_RESET  = 8'd10;
    localparam logic [ALPHA_W:0]   ONE_Q16     = 17'h1_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 1'b0,
        CFG_INTERVAL = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ACC_W-1:0] accel_x;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_z;
    } t_in_item;

    typedef struct packed {
        logic [RMS_W-1:0]  rms_q8;
        logic [FCNT_W-1:0] fill_count;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GRAV_MUL,
        ST_GRAV_ADD,
        ST_GRAV_UPD,
        ST_DYN_SQ,
        ST_SQ_ACC,
        ST_RING,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RESULT
    } t_state;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_DIV,
        DS_SQRT
    } t_ds_phase;

endpackage

@@ sv/vmr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module vmr_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 100,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/vmr_mul.sv @@
// Shared signed multiplier with registered product.
module vmr_mul (
    input  logic                                i_clk,
    input  logic signed [vmr_pkg::MUL_A_W-1:0]  i_a,
    input  logic signed [vmr_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [vmr_pkg::MUL_P_W-1:0]  o_prod
);

    logic signed [vmr_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ sv/vmr_divsqrt.sv @@
// Bit-serial divider followed by bit-serial square root on one shared subtractor.
module vmr_divsqrt #(
    parameter int NUM_W = 57,
    parameter int DEN_W = 7,
    localparam int ROOT_W = (NUM_W + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int PAD_W = 2 * ROOT_W;
    localparam int SUB_W = (ROOT_W + 2 > DEN_W + 1) ? ROOT_W + 2 : DEN_W + 1;
    localparam int CNT_W = $clog2(NUM_W);

    vmr_pkg::t_ds_phase r_phase;
    logic [CNT_W-1:0]   r_cnt;
    logic [PAD_W-1:0]   r_work;     // dividend/quotient, then radicand
    logic [SUB_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [DEN_W-1:0]   r_den;
    logic               r_done;

    logic [SUB_W-1:0]   w_op_a;
    logic [SUB_W-1:0]   w_op_b;
    logic [SUB_W:0]     w_diff;
    logic               w_ge;

    // one compare/subtract serves both phases
    always_comb begin
        if (r_phase == vmr_pkg::DS_SQRT) begin
            w_op_a = {r_rem[SUB_W-3:0], r_work[PAD_W-1 -: 2]};
            w_op_b = SUB_W'({r_root, 2'b01});
        end else begin
            w_op_a = SUB_W'({r_rem[DEN_W-1:0], r_work[NUM_W-1]});
            w_op_b = SUB_W'(r_den);
        end
    end

    assign w_diff = {1'b0, w_op_a} - {1'b0, w_op_b};
    assign w_ge   = ~w_diff[SUB_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= vmr_pkg::DS_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done is registered and rises in the cycle after the last root step
            r_done <= (r_phase == vmr_pkg::DS_SQRT) && (r_cnt == '0);
            case (r_phase)
                vmr_pkg::DS_IDLE: begin
                    if (i_start) begin
                        r_phase <= vmr_pkg::DS_DIV;
                        r_cnt   <= CNT_W'(NUM_W - 1);
                        r_work  <= PAD_W'(i_num);
                        r_rem   <= '0;
                        r_den   <= i_den;
                    end
                end
                vmr_pkg::DS_DIV: begin
                    r_work <= PAD_W'({r_work[NUM_W-2:0], w_ge});
                    if (r_cnt == '0) begin
                        r_phase <= vmr_pkg::DS_SQRT;
                        r_cnt   <= CNT_W'(ROOT_W - 1);
                        r_rem   <= '0;
                        r_root  <= '0;
                    end else begin
                        r_rem <= w_ge ? w_diff[SUB_W-1:0] : w_op_a;
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                vmr_pkg::DS_SQRT: begin
                    r_work <= r_work << 2;
                    r_rem  <= w_ge ? w_diff[SUB_W-1:0] : w_op_a;
                    r_root <= {r_root[ROOT_W-2:0], w_ge};
                    if (r_cnt == '0) begin
                        r_phase <= vmr_pkg::DS_IDLE;
                    end else begin
                        r_cnt <= r_cnt - CNT_W'(1);
                    end
                end
                default: begin
                    r_phase <= vmr_pkg::DS_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

@@ sv/vibration_moving_rms_top.sv @@
// Top level of the vibration moving RMS block: sequencer, state and window ring.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+------------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_data  (accel_x/y/z)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (rms_q8, fill_count)
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_idx, i_cfg_data
//
//  A request without a result occupies the block for its accept cycle, three
//  axis passes through the shared multiplier and one ring update; the first
//  request after reset loads gravity directly and skips the gravity update.
//  A request with a result then runs the bit-serial divide and square root
//  on a NUM_W-bit numerator (NUM_W = 50 + clog2(WINDOW_LEN)).
//  o_in_ready is high only in the idle state and never during reset; a finished
//  result waits in the output register, so the next request is taken while it is
//  still pending. A second result stalls until the output register frees up.
//  Reset is synchronous; no clearing pass, ring data is used only once every entry is written.
module vibration_moving_rms_top #(
    parameter int WINDOW_LEN = 100
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [vmr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [vmr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  vmr_pkg::t_in_item                 i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output vmr_pkg::t_out_item                o_out_data
);

    localparam int IDX_W  = $clog2(WINDOW_LEN);
    localparam int FILL_W = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = vmr_pkg::SQ_W + $clog2(WINDOW_LEN);
    localparam int NUM_W  = SUM_W + vmr_pkg::Q_SH;
    localparam int ROOT_W = (NUM_W + 1) / 2;

    localparam int ACC_W   = vmr_pkg::ACC_W;
    localparam int G_W     = vmr_pkg::G_W;
    localparam int Q_SH    = vmr_pkg::Q_SH;
    localparam int DYN_W   = vmr_pkg::DYN_W;
    localparam int SQ_W    = vmr_pkg::SQ_W;
    localparam int MUL_A_W = vmr_pkg::MUL_A_W;
    localparam int MUL_B_W = vmr_pkg::MUL_B_W;
    localparam int MUL_P_W = vmr_pkg::MUL_P_W;
    localparam int ALPHA_W = vmr_pkg::ALPHA_W;
    localparam int INTV_W  = vmr_pkg::INTV_W;
    localparam int AXIS_W  = vmr_pkg::AXIS_W;

    // ---------------- registers
    vmr_pkg::t_state          r_state, n_state;
    logic [ALPHA_W-1:0]       r_alpha;
    logic [INTV_W-1:0]        r_intv;
    logic signed [ACC_W-1:0]  r_accel [vmr_pkg::NUM_AXES];
    logic signed [G_W-1:0]    r_grav  [vmr_pkg::NUM_AXES];
    logic                     r_gvalid;
    logic [AXIS_W-1:0]        r_axis;
    logic signed [MUL_P_W-1:0] r_acc;   // alpha * g, held for the second product
    logic [SQ_W-1:0]          r_sq;
    logic [SUM_W-1:0]         r_sum;
    logic [IDX_W-1:0]         r_widx;
    logic [FILL_W-1:0]        r_fill;
    logic [INTV_W-1:0]        r_sc;
    logic                     r_out_valid;
    vmr_pkg::t_out_item       r_out;

    // ---------------- datapath nets
    logic                      w_accept;
    logic signed [ACC_W-1:0]   w_a;
    logic signed [G_W-1:0]     w_g;
    logic signed [G_W-1:0]     w_g_load;
    logic signed [G_W:0]       w_diff;
    logic signed [G_W:0]       w_dfl;
    logic                      w_round;
    logic [G_W:0]              w_dtr;
    logic signed [DYN_W-1:0]   w_dyn;
    logic [ALPHA_W:0]          w_beta;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [MUL_P_W-1:0] w_prod;
    logic signed [MUL_P_W-1:0] w_gsum;
    logic                      w_full;
    logic [SQ_W-1:0]           w_old;
    logic [SUM_W-1:0]          w_sum_next;
    logic [INTV_W-1:0]         w_sc_inc;
    logic                      w_emit;
    logic                      w_ds_start;
    logic                      w_ds_done;
    logic [ROOT_W-1:0]         w_root;
    logic                      w_load_out;

    assign w_accept = i_in_valid && o_in_ready;

    // current axis operands
    assign w_a = r_accel[r_axis];
    assign w_g = r_grav[r_axis];

    // first sample: gravity = a * 2^16
    assign w_g_load = {{(G_W - ACC_W - Q_SH){w_a[ACC_W-1]}}, w_a, {Q_SH{1'b0}}};

    // dynamic part: (a * 2^16 - g) / 2^16, truncated toward zero
    assign w_diff  = {w_g_load[G_W-1], w_g_load} - {w_g[G_W-1], w_g};
    assign w_dfl   = w_diff >>> Q_SH;
    assign w_round = w_diff[G_W] && (w_diff[Q_SH-1:0] != '0);
    assign w_dtr   = w_dfl + (G_W + 1)'(w_round);
    assign w_dyn   = w_dtr[DYN_W-1:0];

    assign w_beta  = vmr_pkg::ONE_Q16 - {1'b0, r_alpha};

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_state)
            vmr_pkg::ST_GRAV_MUL: begin
                w_mul_a = {2'b00, r_alpha};
                w_mul_b = {w_g[G_W-1], w_g};
            end
            vmr_pkg::ST_GRAV_ADD: begin
                w_mul_a = {1'b0, w_beta};
                w_mul_b = {{(MUL_B_W - ACC_W){w_a[ACC_W-1]}}, w_a};
            end
            vmr_pkg::ST_DYN_SQ: begin
                w_mul_a = {{(MUL_A_W - DYN_W){w_dyn[DYN_W-1]}}, w_dyn};
                w_mul_b = {{(MUL_B_W - DYN_W){w_dyn[DYN_W-1]}}, w_dyn};
            end
            default: begin
            end
        endcase
    end

    vmr_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // g' = floor((alpha*g + beta*a*2^16) / 2^16); arithmetic shift floors
    assign w_gsum = r_acc + (w_prod <<< Q_SH);

    // window ring
    vmr_ram #(
        .WIDTH (SQ_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (r_state == vmr_pkg::ST_RING),
        .i_waddr (r_widx),
        .i_wdata (r_sq),
        .i_re    (w_accept),
        .i_raddr (r_widx),
        .o_rdata (w_old)
    );

    assign w_full     = (r_fill == FILL_W'(WINDOW_LEN));
    assign w_sum_next = r_sum + SUM_W'(r_sq) - (w_full ? SUM_W'(w_old) : '0);

    // emit when the count reaches the interval or wraps; interval zero acts as one
    assign w_sc_inc = r_sc + INTV_W'(1);
    assign w_emit   = (w_sc_inc >= r_intv) || (w_sc_inc == '0);

    assign w_ds_start = (r_state == vmr_pkg::ST_DIV_START);

    vmr_divsqrt #(
        .NUM_W (NUM_W),
        .DEN_W (FILL_W)
    ) u_divsqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_ds_start),
        .i_num   ({r_sum, {Q_SH{1'b0}}}),
        .i_den   (r_fill),
        .o_done  (w_ds_done),
        .o_root  (w_root)
    );

    assign w_load_out = (r_state == vmr_pkg::ST_RESULT) && (!r_out_valid || i_out_ready);

    // ---------------- sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            vmr_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = vmr_pkg::ST_GRAV_MUL;
                end
            end
            vmr_pkg::ST_GRAV_MUL: begin
                n_state = r_gvalid ? vmr_pkg::ST_GRAV_ADD : vmr_pkg::ST_DYN_SQ;
            end
            vmr_pkg::ST_GRAV_ADD: n_state = vmr_pkg::ST_GRAV_UPD;
            vmr_pkg::ST_GRAV_UPD: n_state = vmr_pkg::ST_DYN_SQ;
            vmr_pkg::ST_DYN_SQ:   n_state = vmr_pkg::ST_SQ_ACC;
            vmr_pkg::ST_SQ_ACC: begin
                if (r_axis == AXIS_W'(vmr_pkg::NUM_AXES - 1)) begin
                    n_state = vmr_pkg::ST_RING;
                end else begin
                    n_state = vmr_pkg::ST_GRAV_MUL;
                end
            end
            vmr_pkg::ST_RING: begin
                n_state = w_emit ? vmr_pkg::ST_DIV_START : vmr_pkg::ST_IDLE;
            end
            vmr_pkg::ST_DIV_START: n_state = vmr_pkg::ST_DIV_WAIT;
            vmr_pkg::ST_DIV_WAIT: begin
                if (w_ds_done) begin
                    n_state = vmr_pkg::ST_RESULT;
                end
            end
            vmr_pkg::ST_RESULT: begin
                if (w_load_out) begin
                    n_state = vmr_pkg::ST_IDLE;
                end
            end
            default: n_state = vmr_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vmr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= vmr_pkg::ALPHA_RESET;
            r_intv  <= vmr_pkg::INTV_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                vmr_pkg::CFG_ALPHA:    r_alpha <= i_cfg_data[ALPHA_W-1:0];
                vmr_pkg::CFG_INTERVAL: r_intv  <= i_cfg_data[INTV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < vmr_pkg::NUM_AXES; i++) begin
                r_grav[i] <= '0;
            end
            r_gvalid <= 1'b0;
            r_sum    <= '0;
            r_widx   <= '0;
            r_fill   <= '0;
            r_sc     <= '0;
        end else begin
            case (r_state)
                vmr_pkg::ST_GRAV_MUL: begin
                    if (!r_gvalid) begin
                        r_grav[r_axis] <= w_g_load;
                    end
                end
                vmr_pkg::ST_GRAV_UPD: begin
                    r_grav[r_axis] <= w_gsum[Q_SH +: G_W];
                end
                vmr_pkg::ST_RING: begin
                    r_gvalid <= 1'b1;
                    r_sum    <= w_sum_next;
                    if (!w_full) begin
                        r_fill <= r_fill + FILL_W'(1);
                    end
                    if (r_widx == IDX_W'(WINDOW_LEN - 1)) begin
                        r_widx <= '0;
                    end else begin
                        r_widx <= r_widx + IDX_W'(1);
                    end
                    r_sc <= w_emit ? '0 : w_sc_inc;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- per-request working registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_accel[0] <= i_in_data.accel_x;
            r_accel[1] <= i_in_data.accel_y;
            r_accel[2] <= i_in_data.accel_z;
            r_axis     <= '0;
            r_sq       <= '0;
        end
        if (r_state == vmr_pkg::ST_GRAV_ADD) begin
            r_acc <= w_prod;
        end
        if (r_state == vmr_pkg::ST_SQ_ACC) begin
            r_sq   <= r_sq + w_prod[SQ_W-1:0];
            r_axis <= r_axis + AXIS_W'(1);
        end
        if (w_load_out) begin
            r_out.rms_q8     <= vmr_pkg::RMS_W'(w_root);
            r_out.fill_count <= vmr_pkg::FCNT_W'(r_fill);
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // no request is taken while reset is held
    assign o_in_ready  = i_rst_n && (r_state == vmr_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WINDOW_LEN))
        else $error("fill counter beyond window length");

    a_widx_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> (FILL_W'(r_widx) == r_fill))
        else $error("write index out of step with fill count before wrap");

    a_gravity_after_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gvalid |-> (r_fill != '0))
        else $error("gravity marked valid with empty window");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready)
        else $error("ready again right after a request was taken");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ds_done |-> (r_state == vmr_pkg::ST_DIV_WAIT))
        else $error("root finished outside the wait state");
`endif

endmodule
